>>> rtl/core/wpst_pkg.sv
// Shared types and constants for the wheel pulse speed tracker.
`default_nettype none
package wpst_pkg;
   localparam logic [14:0] SpeedMax = 15'd25344;
   localparam logic [9:0]  MsPerS   = 10'd1000;

   typedef enum logic [1:0] {
      CSR_CIRC  = 2'd0,
      CSR_SPEED = 2'd1,
      CSR_DIST  = 2'd2,
      CSR_EN    = 2'd3
   } csr_index_type;

   // Task handed from front to back.
   typedef struct packed {
      logic [15:0] interval;
      logic        calc_en;
   } task_type;

   typedef struct packed {
      logic [14:0] current_speed;
      logic [14:0] average_speed;
      logic [47:0] distance_total;
      logic [39:0] elapsed_ms;
      logic [31:0] pulse_count;
   } result_type;
endpackage
`default_nettype wire

>>> rtl/core/wpst_if.sv
// Valid/ready channel interfaces.
`default_nettype none
interface wpst_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pulse_interval_ms;
   modport source (output valid, output pulse_interval_ms, input ready);
   modport sink   (input valid, input pulse_interval_ms, output ready);
endinterface

interface wpst_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] current_speed;
   logic [14:0] average_speed;
   logic [47:0] distance_total;
   logic [39:0] elapsed_ms;
   logic [31:0] pulse_count;
   modport source (output valid, output current_speed, output average_speed,
                   output distance_total, output elapsed_ms, output pulse_count,
                   input ready);
   modport sink   (input valid, input current_speed, input average_speed,
                   input distance_total, input elapsed_ms, input pulse_count,
                   output ready);
endinterface

interface wpst_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/wpst_queue.sv
// Two-entry task queue between front and back.
`default_nettype none
module wpst_queue
   import wpst_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire task_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output task_type      pop_data
);
   task_type   mem_ff [2];
   task_type   mem_in [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      mem_in = mem_ff;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         mem_in[wr_ff] = push_data;
         wr_in = ~wr_ff;
      end
      if (pop) rd_in = ~rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign full     = cnt_ff[1];
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];
endmodule
`default_nettype wire

>>> rtl/core/wpst_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wpst_divider #(
   parameter int NumW = 48,
   parameter int DenW = 24
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [NumW-1:0] num,
   input  wire logic [DenW-1:0] den,
   output logic                 done,
   output logic [NumW-1:0]      quo
);
   localparam int CntW = $clog2(NumW + 1);
   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0]   r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [DenW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DenW-1:0], q_ff[NumW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = CntW'(NumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule
`default_nettype wire

>>> rtl/core/wpst_back.sv
// Back end: speed, mean, distance and time update sequencer.
`default_nettype none
module wpst_back
   import wpst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [11:0] circ,
   input  wire logic [23:0] speed_factor,
   input  wire logic [31:0] dist_factor,
   input  wire logic        q_empty,
   input  wire task_type    q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rsp_data
);
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL1 = 8'b0000_0010,
      ST_MUL2 = 8'b0000_0100,
      ST_MUL3 = 8'b0000_1000,
      ST_DIV1 = 8'b0001_0000,
      ST_DIV2 = 8'b0010_0000,
      ST_OUT  = 8'b0100_0000,
      ST_HOLD = 8'b1000_0000
   } state_type;

   state_type   st_ff, st_in;
   task_type    tk_ff, tk_in;
   logic [35:0] p1_ff, p1_in;       // circ * speed_factor
   logic [45:0] num_ff, num_in;     // * 1000
   logic [43:0] step_ff, step_in;   // circ * dist_factor
   logic [14:0] cur_ff, cur_in;
   logic [14:0] avg_ff, avg_in;
   logic [47:0] dist_ff, dist_in;
   logic [39:0] el_ff, el_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        avg_up_ff, avg_up_in;
   result_type  res_ff, res_in;
   logic        vld_ff, vld_in;

   logic        div_start;
   logic [47:0] div_num, div_quo;
   logic [23:0] div_den;
   logic        div_done;
   logic [48:0] dsum;
   logic [40:0] esum;
   logic [14:0] diff;

   wpst_divider #(.NumW(48), .DenW(24)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quo(div_quo)
   );

   always_comb begin
      st_in = st_ff; tk_in = tk_ff; p1_in = p1_ff; num_in = num_ff;
      step_in = step_ff; cur_in = cur_ff; avg_in = avg_ff; dist_in = dist_ff;
      el_in = el_ff; cnt_in = cnt_ff; avg_up_in = avg_up_ff;
      res_in = res_ff; vld_in = vld_ff;
      q_pop = 1'b0; div_start = 1'b0; div_num = '0; div_den = '0;
      dsum = '0; esum = '0; diff = '0;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               tk_in = q_data; q_pop = 1'b1; st_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            p1_in   = 36'(circ) * 36'(speed_factor);
            step_in = 44'(circ) * 44'(dist_factor);
            st_in   = ST_MUL2;
         end
         ST_MUL2: begin
            num_in = 46'(p1_ff) * 46'(MsPerS);
            esum = {1'b0, el_ff} + 41'(tk_ff.interval);
            el_in = esum[40] ? '1 : esum[39:0];
            st_in = ST_MUL3;
         end
         ST_MUL3: begin
            if (tk_ff.interval == '0) begin
               cur_in = SpeedMax;
               st_in  = ST_DIV2;
            end else begin
               div_start = 1'b1;
               div_num = 48'(num_ff);
               div_den = {tk_ff.interval, 8'd0};
               st_in = ST_DIV1;
            end
            if (tk_ff.calc_en) begin
               if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
               dsum = {1'b0, dist_ff} + 49'(step_ff);
               dist_in = dsum[48] ? '1 : dsum[47:0];
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               cur_in = (div_quo > 48'(SpeedMax)) ? SpeedMax : div_quo[14:0];
               st_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            // mean update: |cur - avg| / count, count nonzero when enabled
            avg_up_in = (cur_ff >= avg_ff);
            diff = (cur_ff >= avg_ff) ? cur_ff - avg_ff : avg_ff - cur_ff;
            if (tk_ff.calc_en) begin
               div_start = 1'b1;
               div_num = 48'(diff);
               div_den = (cnt_ff[31:15] != '0) ? 24'hFF_FFFF : 24'(cnt_ff[14:0]);
               st_in = ST_HOLD;
            end else begin
               st_in = ST_OUT;
            end
         end
         ST_HOLD: begin
            if (div_done) begin
               avg_in = avg_up_ff ? avg_ff + div_quo[14:0] : avg_ff - div_quo[14:0];
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!vld_ff || rsp_ready) begin
               res_in.current_speed  = cur_ff;
               res_in.average_speed  = avg_ff;
               res_in.distance_total = dist_ff;
               res_in.elapsed_ms     = el_ff;
               res_in.pulse_count    = cnt_ff;
               vld_in = 1'b1;
               st_in  = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tk_ff <= tk_in; p1_ff <= p1_in; num_ff <= num_in; step_ff <= step_in;
      cur_ff <= cur_in; avg_up_ff <= avg_up_in; res_ff <= res_in;
      if (reset) begin
         st_ff <= ST_IDLE; vld_ff <= 1'b0;
         avg_ff <= '0; dist_ff <= '0; el_ff <= '0; cnt_ff <= '0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
         avg_ff <= avg_in; dist_ff <= dist_in; el_ff <= el_in; cnt_ff <= cnt_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = res_ff;
endmodule
`default_nettype wire

>>> rtl/core/wheel_pulse_speed_tracker_core.sv
// Top level of the wheel pulse speed tracker.
// Each req beat carries the ms between two wheel pulses; one rsp beat comes
// back per req beat with current speed (Q7.8, clamped to 99.0), running mean
// speed, distance (Q16.32), elapsed ms and pulse count, all saturating.
// Settings live in four csr registers (circumference, speed factor, distance
// factor, enable) written by index; write them only while idle. The front
// end latches the interval and the enable bit into a two-entry queue; the
// back end works one item at a time. After a queue pop it steps through
// its sequencing states and uses the shared 48-step restoring divider
// twice (speed, then mean update). One divider pass is skipped when
// enable is off or the interval is zero; with both, neither pass runs.
// rsp valid rises as the result register loads, and a stalled rsp holds
// the back end in its output state.
`default_nettype none
module wheel_pulse_speed_tracker_core
   import wpst_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wpst_req_if.sink   req,
   wpst_rsp_if.source rsp,
   wpst_csr_if.sink   csr
);
   logic [11:0] circ_ff;
   logic [23:0] sf_ff;
   logic [31:0] df_ff;
   logic        en_ff;
   logic        q_full, q_empty, q_pop, push;
   task_type    q_data, push_data;
   result_type  res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= 12'd2100;
         sf_ff   <= 24'd235930;
         df_ff   <= 32'd4295;
         en_ff   <= 1'b1;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_CIRC:  circ_ff <= csr.data[11:0];
            CSR_SPEED: sf_ff   <= csr.data[23:0];
            CSR_DIST:  df_ff   <= csr.data;
            CSR_EN:    en_ff   <= csr.data[0];
            default:   ;
         endcase
      end
   end
   assign csr.ready = 1'b1;

   // front end: take beat, tag with enable, queue it
   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;
   assign push_data = '{interval: req.pulse_interval_ms, calc_en: en_ff};

   wpst_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .full(q_full), .pop(q_pop), .empty(q_empty), .pop_data(q_data)
   );

   wpst_back u_back (
      .clock(clock), .reset(reset), .circ(circ_ff), .speed_factor(sf_ff),
      .dist_factor(df_ff), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(res)
   );

   assign rsp.current_speed  = res.current_speed;
   assign rsp.average_speed  = res.average_speed;
   assign rsp.distance_total = res.distance_total;
   assign rsp.elapsed_ms     = res.elapsed_ms;
   assign rsp.pulse_count    = res.pulse_count;
endmodule
`default_nettype wire
